>>> rtl/core/lfht_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lfht_pkg
// Shared types, constants and helpers for the lowest-free handle table.
// ============================================================================
package lfht_pkg;

    localparam int SLOTS        = 4096;
    localparam int HANDLE_BITS  = 32;
    localparam int SLOT_BITS    = 12;
    localparam int SIZE_BITS    = 13;
    localparam int ROW_WIDTH    = 64;
    localparam int BIT_IDX_BITS = $clog2(ROW_WIDTH);
    localparam int ROWS         = SLOTS / ROW_WIDTH;
    localparam int ROW_IDX_BITS = $clog2(ROWS);
    localparam int SLOT_AW      = ROW_IDX_BITS + BIT_IDX_BITS;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(SLOTS);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX   = SIZE_BITS'(SLOTS);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_GET   = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_NULL  = 3'd4;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [SLOT_BITS-1:0]   slot;
        logic [HANDLE_BITS-1:0] handle;
    } lfht_in_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [SLOT_BITS-1:0]   slot_out;
        logic [HANDLE_BITS-1:0] handle_out;
        logic                   take_ref;
        logic                   release_ref;
    } lfht_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request
        logic save_early;  // register a result decided without the store
        logic issue_read;  // read the occupancy row and the handle store
        logic eval;        // decide from the row, commit writes, register result
        logic push_out;    // move the result into the output register
    } lfht_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early_fail;
        logic out_free;
    } lfht_sts_t;

    // Index of the lowest clear bit of a row. The add isolates that bit as a
    // one-hot word, which is then encoded bit by bit.
    function automatic logic [BIT_IDX_BITS-1:0] lowest_zero(input logic [ROW_WIDTH-1:0] v);
        logic [ROW_WIDTH-1:0]    oh;
        logic [BIT_IDX_BITS-1:0] idx;
        oh  = ~v & (v + ROW_WIDTH'(1));
        idx = '0;
        for (int i = 0; i < ROW_WIDTH; i++) begin
            if (oh[i])
            begin
                idx = idx | BIT_IDX_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/core/lfht_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// lfht_ctrl
// Request sequencer: capture, early check, store read, evaluate, hand off.
// ============================================================================
module lfht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lfht_pkg::lfht_sts_t sts,
    output lfht_pkg::lfht_ctl_t ctl
);
    import lfht_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.early_fail)
                begin
                    ctl.save_early = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    ctl.issue_read = 1'b1;
                    state_next     = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.eval   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The evaluation step always works on data read in the cycle before.
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.eval |-> $past(ctl.issue_read))
        else $error("evaluation without a preceding store read");

endmodule

>>> rtl/core/lfht_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// lfht_datapath
// Handle store, occupancy rows with summary, size register and result path.
// ============================================================================
module lfht_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lfht_pkg::lfht_in_t             in_data,
    input  logic                           cfg_valid,
    input  logic [lfht_pkg::SIZE_BITS-1:0] cfg_data,
    input  lfht_pkg::lfht_ctl_t            ctl,
    output lfht_pkg::lfht_sts_t            sts,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lfht_pkg::lfht_out_t            out_data
);
    import lfht_pkg::*;

    // Storage.
    logic [HANDLE_BITS-1:0] handle_mem [SLOTS];
    logic [ROW_WIDTH-1:0]   row_mem [ROWS];

    lfht_in_t               req_reg;
    logic [SIZE_BITS-1:0]   table_size_reg;
    logic [ROWS-1:0]        full_reg;
    logic [ROWS-1:0]        row_valid_reg;
    logic [ROW_WIDTH-1:0]   row_q_reg;
    logic                   row_q_valid_reg;
    logic [HANDLE_BITS-1:0] handle_q_reg;
    logic [ROW_IDX_BITS-1:0] row_idx_reg;
    lfht_out_t              res_reg;
    lfht_out_t              out_reg;
    logic                   out_valid_reg;

    logic [SIZE_BITS-1:0]    eff_size;
    logic                    is_alloc;
    logic                    is_free;
    logic                    range_bad;
    lfht_out_t               early_res;
    logic [ROW_IDX_BITS-1:0] rd_row;
    logic [ROW_WIDTH-1:0]    row_word;
    logic [BIT_IDX_BITS-1:0] pick_bit;
    logic [BIT_IDX_BITS-1:0] use_bit;
    logic [SLOT_AW-1:0]      new_slot;
    logic                    alloc_ok;
    logic                    occupied;
    logic [ROW_WIDTH-1:0]    bit_mask;
    logic                    wr_row_en;
    logic [ROW_WIDTH-1:0]    wr_row_data;
    logic                    hm_wr_en;
    lfht_out_t               eval_res;

    assign eff_size = (table_size_reg > SIZE_MAX) ? SIZE_MAX : table_size_reg;
    assign is_alloc = (req_reg.cmd == CMD_ALLOC);
    assign is_free  = (req_reg.cmd == CMD_FREE);
    assign range_bad = (req_reg.cmd == CMD_RSVD) ||
                       ({1'b0, req_reg.slot} >= eff_size);

    always_comb
    begin
        early_res = '0;
        if (is_alloc)
        begin
            early_res.status   = (req_reg.handle == '0) ? ST_NULL : ST_FULL;
            early_res.slot_out = '1;
        end
        else
        begin
            early_res.status   = ST_RANGE;
            early_res.slot_out = req_reg.slot;
        end
    end

    assign sts.early_fail = is_alloc ? ((req_reg.handle == '0) || (&full_reg)) : range_bad;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign rd_row = is_alloc ? lowest_zero(full_reg)
                             : req_reg.slot[SLOT_AW-1:BIT_IDX_BITS];

    // Evaluation on the registered row.
    assign row_word = row_q_valid_reg ? row_q_reg : '0;
    assign pick_bit = lowest_zero(row_word);
    assign new_slot = {row_idx_reg, pick_bit};
    assign alloc_ok = ({1'b0, new_slot} < eff_size);
    assign use_bit  = is_alloc ? pick_bit : req_reg.slot[BIT_IDX_BITS-1:0];
    assign occupied = row_word[use_bit];
    assign bit_mask = ROW_WIDTH'(1) << use_bit;

    assign hm_wr_en    = ctl.eval && is_alloc && alloc_ok;
    assign wr_row_en   = hm_wr_en || (ctl.eval && is_free && occupied);
    assign wr_row_data = is_alloc ? (row_word | bit_mask) : (row_word & ~bit_mask);

    always_comb
    begin
        eval_res = '0;
        if (is_alloc)
        begin
            if (alloc_ok)
            begin
                eval_res.status     = ST_OK;
                eval_res.slot_out   = new_slot;
                eval_res.handle_out = req_reg.handle;
                eval_res.take_ref   = 1'b1;
            end
            else
            begin
                eval_res.status   = ST_FULL;
                eval_res.slot_out = '1;
            end
        end
        else
        begin
            eval_res.slot_out = req_reg.slot;
            if (occupied)
            begin
                eval_res.status      = ST_OK;
                eval_res.handle_out  = handle_q_reg;
                eval_res.take_ref    = !is_free;
                eval_res.release_ref = is_free;
            end
            else
            begin
                eval_res.status = ST_EMPTY;
            end
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (hm_wr_en)
        begin
            handle_mem[new_slot] <= req_reg.handle;
        end
        if (ctl.issue_read)
        begin
            handle_q_reg <= handle_mem[req_reg.slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_row_en)
        begin
            row_mem[row_idx_reg] <= wr_row_data;
        end
        if (ctl.issue_read)
        begin
            row_q_reg <= row_mem[rd_row];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= in_data;
        end
        if (ctl.issue_read)
        begin
            row_idx_reg <= rd_row;
        end
        if (ctl.save_early)
        begin
            res_reg <= early_res;
        end
        else if (ctl.eval)
        begin
            res_reg <= eval_res;
        end
        if (ctl.push_out)
        begin
            out_reg <= res_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg  <= SIZE_RESET;
            full_reg        <= '0;
            row_valid_reg   <= '0;
            row_q_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                table_size_reg <= cfg_data;
            end
            if (ctl.issue_read)
            begin
                row_q_valid_reg <= row_valid_reg[rd_row];
            end
            if (wr_row_en)
            begin
                row_valid_reg[row_idx_reg] <= 1'b1;
                full_reg[row_idx_reg]      <= &wr_row_data;
            end
            if (ctl.push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The summary must only ever steer an allocation to a row with room.
    a_alloc_row_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.eval && is_alloc) |-> (row_word != '1))
        else $error("allocation evaluated a full occupancy row");

    // Freeing a slot leaves its row marked as having room.
    a_free_clears_full: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_row_en && !is_alloc) |=> !full_reg[$past(row_idx_reg)])
        else $error("row still marked full after a free");

    // A failed request never asks the caller to touch a reference.
    a_fail_no_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != ST_OK)) |->
            (!out_reg.take_ref && !out_reg.release_ref && (out_reg.handle_out == '0)))
        else $error("failure result carries a reference or a handle");

endmodule

>>> rtl/core/lowest_free_handle_table_core.sv
`timescale 1ns / 1ps
// ============================================================================
// lowest_free_handle_table_core
// Slot table that hands out the lowest free slot for a nonzero handle.
// ============================================================================
// Usage:
// The request channel (in_valid/in_ready/in_data) carries one command per
// transfer: allocate, free a slot or get a slot. Every request produces
// exactly one transfer on the result channel (out_valid/out_ready/out_data)
// with a status, the slot, the handle and the reference hints.
// The table size is written over cfg_valid/cfg_ready/cfg_data, which is
// always ready; it must only change while no request is in flight.
// Each request steps through the sequencer before the next request can be
// taken: capture, the check against the occupancy summary together with
// one registered read of the occupancy row and handle store, evaluation and
// commit, then the move into the output register.
// Requests that fail early (null handle, table full, slot out of range)
// skip the store read and the evaluation step.
// The result waits in an output register; while the receiver stalls, one
// more request may be processed and then holds until the register frees.
// Reset empties the table at once: per-row valid bits make unwritten rows
// read as empty, so no clearing pass is needed. Size resets to 4096.
// ============================================================================
module lowest_free_handle_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  lfht_pkg::lfht_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output lfht_pkg::lfht_out_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfht_pkg::SIZE_BITS-1:0] cfg_data
);
    import lfht_pkg::*;

    lfht_ctl_t ctl;
    lfht_sts_t sts;

    // The size register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer that steps each request through the datapath.
    lfht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Store, occupancy tracking and the result registers.
    lfht_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> bench/lowest_free_handle_table_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// lowest_free_handle_table_core_test
// Self-checking bench for the lowest-free handle table core.
// ============================================================================
// A shadow copy of the slot store and the table size predicts the result of
// every request at the moment its transfer is accepted. Each result transfer
// is then checked field by field against the oldest prediction.
// A short directed section covers reset contents, the reference hints, the
// lowest-slot choice, null handles, the unused command, full tables, empty
// slots and out-of-range slots. Random traffic follows at several table sizes,
// including zero, one, the full 4096 and an oversized value that saturates.
// The request side sends in bursts with random gaps. The result side stalls
// in changing patterns.
// ============================================================================
module lowest_free_handle_table_core_test;

    import lfht_pkg::*;

    // The longest stretch without any transfer that a correct run can show is
    // a sender gap or a receiver stall. This limit is far beyond either.
    localparam int unsigned STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    lfht_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    lfht_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SIZE_BITS-1:0] cfg_data = SIZE_RESET;

    // Shadow state of the table, advanced once per accepted request.
    logic [HANDLE_BITS-1:0] shadow_handles [SLOTS];
    logic [SIZE_BITS-1:0] shadow_size = SIZE_RESET;

    // Predicted results, oldest first.
    lfht_out_t expected_responses [$];

    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;

    lowest_free_handle_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_handles[i] = '0;
        end
    end

    // Number of slots actually searched: the size register saturates at the
    // table depth, and a size of zero leaves no slot active.
    function automatic int unsigned active_slots();
        return (shadow_size > SIZE_MAX) ? SLOTS : int'(shadow_size);
    endfunction

    // Works out the result of one request and applies its effect on the
    // shadow store. Allocation stores into the lowest empty active slot.
    function automatic lfht_out_t predict_table_response(input lfht_in_t req);
        lfht_out_t res;
        int unsigned limit;
        int unsigned idx;
        logic found;
        logic [HANDLE_BITS-1:0] held;
        res = '0;
        limit = active_slots();
        if (req.cmd == CMD_ALLOC)
        begin
            res.slot_out = '1;
            if (req.handle == '0)
            begin
                // A null handle is refused before the table is searched.
                res.status = ST_NULL;
            end
            else
            begin
                found = 1'b0;
                idx = 0;
                while (!found && idx < limit)
                begin
                    if (shadow_handles[idx] == '0)
                    begin
                        found = 1'b1;
                    end
                    else
                    begin
                        idx++;
                    end
                end
                if (found)
                begin
                    shadow_handles[idx] = req.handle;
                    res.status = ST_OK;
                    res.slot_out = SLOT_BITS'(idx);
                    res.handle_out = req.handle;
                    res.take_ref = 1'b1;
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
        end
        else
        begin
            res.slot_out = req.slot;
            // The unused command reports like an out-of-range slot.
            if (req.cmd == CMD_RSVD || int'(req.slot) >= limit)
            begin
                res.status = ST_RANGE;
            end
            else
            begin
                held = shadow_handles[req.slot];
                if (held == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.status = ST_OK;
                    res.handle_out = held;
                    if (req.cmd == CMD_FREE)
                    begin
                        shadow_handles[req.slot] = '0;
                        res.release_ref = 1'b1;
                    end
                    else
                    begin
                        res.take_ref = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    // Every accepted request is predicted at the edge of its transfer.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_responses.push_back(predict_table_response(in_data));
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("ERROR at %0t ns: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Result checker: each result transfer is matched against the oldest
    // prediction. Four-state compares catch unknown bits on the outputs.
    always @(posedge clk)
    begin : check_results
        lfht_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_responses.size() == 0)
            begin
                report_mismatch("status of a result nobody asked for",
                                64'(out_data.status), '0);
            end
            else
            begin
                want = expected_responses.pop_front();
                if (out_data.status !== want.status)
                begin
                    report_mismatch("status", 64'(out_data.status), 64'(want.status));
                end
                if (out_data.slot_out !== want.slot_out)
                begin
                    report_mismatch("slot_out", 64'(out_data.slot_out), 64'(want.slot_out));
                end
                if (out_data.handle_out !== want.handle_out)
                begin
                    report_mismatch("handle_out", 64'(out_data.handle_out),
                                    64'(want.handle_out));
                end
                if (out_data.take_ref !== want.take_ref)
                begin
                    report_mismatch("take_ref", 64'(out_data.take_ref), 64'(want.take_ref));
                end
                if (out_data.release_ref !== want.release_ref)
                begin
                    report_mismatch("release_ref", 64'(out_data.release_ref),
                                    64'(want.release_ref));
                end
            end
        end
    end

    // The receiver picks a new behavior after each random span: always ready,
    // coin flips, rarely ready, or a fixed duty cycle.
    always @(posedge clk)
    begin : receiver_stalls
        int unsigned mode;
        int unsigned span;
        if (span == 0)
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
        end
        span--;
        case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((span % 8) < 3);
        endcase
    end

    // Watchdog: a run that stops moving is ended as a failure.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one request. At the start of each burst the sender may pause for
    // a random gap; within a burst valid stays high from one transfer to the
    // next. Returns at the edge where the transfer happens.
    task automatic send_request(input logic [1:0] cmd, input logic [SLOT_BITS-1:0] slot,
                                input logic [HANDLE_BITS-1:0] handle);
        lfht_in_t item;
        int unsigned gap;
        item.cmd = cmd;
        item.slot = slot;
        item.handle = handle;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops sending and waits until every predicted result has been checked,
    // then idles on so the block is fully at rest. The first edge
    // lets the prediction of a transfer at the current edge be queued.
    task automatic drain_requests();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Size changes happen only with no request in flight.
    task automatic set_table_size(input logic [SIZE_BITS-1:0] size_value);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_data <= size_value;
        do @(posedge clk); while (!cfg_ready);
        shadow_size = size_value;
        cfg_valid <= 1'b0;
    endtask

    // Picks an occupied active slot, searching from a random start, so that
    // most frees and gets hit something. Falls back to a random active slot.
    function automatic logic [SLOT_BITS-1:0] find_live_slot();
        int unsigned limit;
        int unsigned start;
        int unsigned idx;
        limit = active_slots();
        if (limit == 0)
        begin
            return SLOT_BITS'($urandom_range(0, SLOTS - 1));
        end
        start = $urandom_range(0, limit - 1);
        for (int unsigned n = 0; n < limit; n++)
        begin
            idx = (start + n) % limit;
            if (shadow_handles[idx] != '0)
            begin
                return SLOT_BITS'(idx);
            end
        end
        return SLOT_BITS'(start);
    endfunction

    // Right after reset every slot is empty and the whole table is active.
    task automatic test_reset_state();
        send_request(CMD_GET, '0, $urandom);
        send_request(CMD_GET, '1, $urandom);
        drain_requests();
    endtask

    // Allocation takes the lowest empty slot, including one freed earlier.
    // Gets and frees return the stored handle with the matching hint.
    task automatic test_alloc_and_get();
        send_request(CMD_ALLOC, SLOT_BITS'($urandom), 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, SLOT_BITS'($urandom), 32'h0000_0001);
        send_request(CMD_GET, 12'd0, $urandom);
        send_request(CMD_GET, 12'd1, $urandom);
        send_request(CMD_FREE, 12'd0, $urandom);
        send_request(CMD_ALLOC, SLOT_BITS'($urandom), 32'h8000_0000);
        send_request(CMD_FREE, 12'd1, $urandom);
        send_request(CMD_FREE, 12'd1, $urandom);
        send_request(CMD_GET, 12'd1, $urandom);
        drain_requests();
    endtask

    // A null handle is refused, and the unused command is reported as out of
    // range at both ends of the slot field.
    task automatic test_null_and_reserved();
        send_request(CMD_ALLOC, '1, '0);
        send_request(CMD_RSVD, '1, $urandom);
        send_request(CMD_RSVD, '0, '1);
        drain_requests();
    endtask

    // A two-slot table fills up; a null handle is still reported as null on a
    // full table. Slots past the size are out of range, and a size of zero
    // leaves nothing to allocate or read.
    task automatic test_full_table();
        set_table_size(13'd2);
        send_request(CMD_ALLOC, SLOT_BITS'($urandom), 32'h5A5A_A5A5);
        send_request(CMD_ALLOC, SLOT_BITS'($urandom), 32'h1234_5678);
        send_request(CMD_ALLOC, SLOT_BITS'($urandom), '0);
        send_request(CMD_GET, 12'd2, $urandom);
        send_request(CMD_FREE, '1, $urandom);
        set_table_size(13'd0);
        send_request(CMD_GET, 12'd0, $urandom);
        send_request(CMD_ALLOC, SLOT_BITS'($urandom), 32'h0000_0007);
        drain_requests();
    endtask

    // Random traffic at one table size. Most requests are allocations and
    // frees or gets of occupied slots; the rest are arbitrary requests that
    // reach empty slots, out-of-range slots and the unused command.
    task automatic test_random_traffic(input logic [SIZE_BITS-1:0] size_value,
                                       input int unsigned count);
        int unsigned roll;
        logic [HANDLE_BITS-1:0] handle;
        set_table_size(size_value);
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            handle = ($urandom_range(0, 31) == 0) ? '0 : HANDLE_BITS'($urandom);
            if (roll < 45)
            begin
                send_request(CMD_ALLOC, SLOT_BITS'($urandom), handle);
            end
            else if (roll < 65)
            begin
                send_request(CMD_FREE, find_live_slot(), handle);
            end
            else if (roll < 85)
            begin
                send_request(CMD_GET, find_live_slot(), handle);
            end
            else
            begin
                send_request(2'($urandom_range(0, 3)), SLOT_BITS'($urandom),
                             HANDLE_BITS'($urandom));
            end
        end
        drain_requests();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_alloc_and_get();
        test_null_and_reserved();
        test_full_table();

        test_random_traffic(13'd8191, 80);
        test_random_traffic(13'd8, 90);
        test_random_traffic(13'd1, 30);
        test_random_traffic(13'd0, 20);
        test_random_traffic(13'd4096, 120);
        test_random_traffic(SIZE_BITS'($urandom_range(2, 100)), 90);
        test_random_traffic(13'd64, 70);

        drain_requests();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
